// ===== design/sfra_pkg.sv =====
// Shared constants and configuration register codes for the stream find-and-replace block.
package sfra_pkg;

    localparam int NEEDLE_MAX_DEF      = 8;
    localparam int REPLACEMENT_MAX_DEF = 16;

    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int NLEN_REG_W  = 4;
    localparam int RLEN_REG_W  = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEEDLE_LENGTH      = 3'd0,
        CFG_NEEDLE_TEXT        = 3'd1,
        CFG_REPLACEMENT_LENGTH = 3'd2,
        CFG_REPLACEMENT_LOW    = 3'd3,
        CFG_REPLACEMENT_HIGH   = 3'd4
    } cfg_index_t;

endpackage

// ===== design/stream_find_replace_all.sv =====
// Stream find-and-replace-all: iterative sequencer over a pending prefix buffer.
// Each result passes through the stage register, which holds one result back, then the output register.
// A new input transaction is accepted only in idle, once the previous one has finished.
// Throughput: one result byte per cycle while a full output is not waiting on m_tready;
// scan or flush steps that emit nothing also hold the flow.
// Reset (aresetn low, synchronous): state, counters and config registers cleared, pending buffer empty, no output.
module stream_find_replace_all
    import sfra_pkg::*;
#(
    parameter int NEEDLE_MAX      = NEEDLE_MAX_DEF,
    parameter int REPLACEMENT_MAX = REPLACEMENT_MAX_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] text_byte
    input  logic                   s_tlast,   // stream_end
    input  logic                   s_tuser,   // [0] byte_present
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // [7:0] result_byte
    output logic                   m_tlast,   // run_last
    output logic                   m_tuser,   // [0] text_done
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NL_W = $clog2(NEEDLE_MAX + 1);
    localparam int RL_W = $clog2(REPLACEMENT_MAX + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_MATCH = 8'b0000_0100,
        ST_FLUSH = 8'b0000_1000,
        ST_PRE   = 8'b0001_0000,
        ST_BYTE  = 8'b0010_0000,
        ST_POST  = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [NLEN_REG_W-1:0] needle_length_reg, needle_length_next;
    logic [CFG_DATA_W-1:0] needle_text_reg, needle_text_next;
    logic [RLEN_REG_W-1:0] repl_length_reg, repl_length_next;
    logic [CFG_DATA_W-1:0] repl_low_reg, repl_low_next;
    logic [CFG_DATA_W-1:0] repl_high_reg, repl_high_next;

    logic [BYTE_W-1:0] pend_reg [NEEDLE_MAX];
    logic [BYTE_W-1:0] pend_next [NEEDLE_MAX];
    logic [NL_W-1:0]   count_reg, count_next;
    logic [RL_W-1:0]   ri_reg, ri_next;

    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              end_reg, end_next;

    logic [BYTE_W-1:0] stage_reg, stage_next;
    logic              stage_valid_reg, stage_valid_next;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_done_reg, m_done_next;

    logic [NL_W-1:0]   nl_eff;
    logic [RL_W-1:0]   rl_eff;
    logic [2*CFG_DATA_W-1:0] repl_all;
    logic [BYTE_W-1:0] repl_byte;
    logic              is_prefix;
    logic              out_free;
    logic              can_emit;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              move_out;
    logic              move_last;
    logic              s_accept;
    logic              ri_at_end;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

    // Clamp oversized lengths to the buffer limits.
    assign nl_eff = (needle_length_reg > NLEN_REG_W'(NEEDLE_MAX))
                    ? NL_W'(NEEDLE_MAX) : NL_W'(needle_length_reg);
    assign rl_eff = (repl_length_reg > RLEN_REG_W'(REPLACEMENT_MAX))
                    ? RL_W'(REPLACEMENT_MAX) : RL_W'(repl_length_reg);

    assign repl_all  = {repl_high_reg, repl_low_reg};
    assign repl_byte = repl_all[8*(32'(ri_reg) & 32'd15) +: 8];
    assign ri_at_end = (RL_W'(ri_reg + 1'b1) == rl_eff);

    assign out_free = !m_valid_reg || m_tready;
    assign can_emit = !stage_valid_reg || out_free;

    always_comb begin
        is_prefix = (count_reg <= nl_eff);
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            if ((NL_W'(k) < count_reg) && (pend_reg[k] != needle_text_reg[8*k +: 8])) begin
                is_prefix = 1'b0;
            end
        end
    end

    always_comb begin
        state_next         = state_reg;
        needle_length_next = needle_length_reg;
        needle_text_next   = needle_text_reg;
        repl_length_next   = repl_length_reg;
        repl_low_next      = repl_low_reg;
        repl_high_next     = repl_high_reg;
        pend_next          = pend_reg;
        count_next         = count_reg;
        ri_next            = ri_reg;
        byte_next          = byte_reg;
        end_next           = end_reg;
        stage_next         = stage_reg;
        stage_valid_next   = stage_valid_reg;
        m_valid_next       = m_valid_reg;
        m_data_next        = m_data_reg;
        m_last_next        = m_last_reg;
        m_done_next        = m_done_reg;
        emit               = 1'b0;
        emit_byte          = '0;
        move_out           = 1'b0;
        move_last          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    byte_next = s_tdata;
                    end_next  = s_tlast;
                    ri_next   = '0;
                    if (nl_eff == '0) begin
                        count_next = '0;
                        if (s_tuser) begin
                            state_next = (rl_eff != '0) ? ST_PRE : ST_BYTE;
                        end else if (s_tlast && (rl_eff != '0)) begin
                            state_next = ST_POST;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end else if (s_tuser) begin
                        for (int k = 0; k < NEEDLE_MAX; k++) begin
                            if (NL_W'(k) == count_reg) begin
                                pend_next[k] = s_tdata;
                            end
                        end
                        count_next = NL_W'(count_reg + 1'b1);
                        state_next = ST_SCAN;
                    end else if (s_tlast) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if ((count_reg != '0) && !is_prefix) begin
                    // drop the front byte to the output and shift the rest down
                    if (can_emit) begin
                        emit      = 1'b1;
                        emit_byte = pend_reg[0];
                        for (int k = 0; k < NEEDLE_MAX - 1; k++) begin
                            pend_next[k] = pend_reg[k+1];
                        end
                        count_next = NL_W'(count_reg - 1'b1);
                    end
                end else if (count_reg == nl_eff) begin
                    count_next = '0;
                    if (rl_eff != '0) begin
                        state_next = ST_MATCH;
                    end else begin
                        state_next = end_reg ? ST_FLUSH : ST_FIN;
                    end
                end else begin
                    state_next = end_reg ? ST_FLUSH : ST_FIN;
                end
            end
            ST_MATCH: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_byte = repl_byte;
                    ri_next   = RL_W'(ri_reg + 1'b1);
                    if (ri_at_end) begin
                        ri_next    = '0;
                        state_next = end_reg ? ST_FLUSH : ST_FIN;
                    end
                end
            end
            ST_FLUSH: begin
                if (count_reg != '0) begin
                    if (can_emit) begin
                        emit      = 1'b1;
                        emit_byte = pend_reg[0];
                        for (int k = 0; k < NEEDLE_MAX - 1; k++) begin
                            pend_next[k] = pend_reg[k+1];
                        end
                        count_next = NL_W'(count_reg - 1'b1);
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_PRE: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_byte = repl_byte;
                    ri_next   = RL_W'(ri_reg + 1'b1);
                    if (ri_at_end) begin
                        ri_next    = '0;
                        state_next = ST_BYTE;
                    end
                end
            end
            ST_BYTE: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    emit_byte  = byte_reg;
                    ri_next    = '0;
                    state_next = (end_reg && (rl_eff != '0)) ? ST_POST : ST_FIN;
                end
            end
            ST_POST: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_byte = repl_byte;
                    ri_next   = RL_W'(ri_reg + 1'b1);
                    if (ri_at_end) begin
                        ri_next    = '0;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // release the held byte as the last result of this transaction
                if (!stage_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    move_out         = 1'b1;
                    move_last        = 1'b1;
                    stage_valid_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Hold one result back so the last one can be marked when the work ends.
        if (emit) begin
            if (stage_valid_reg) begin
                move_out = 1'b1;
            end
            stage_next       = emit_byte;
            stage_valid_next = 1'b1;
        end

        if (move_out) begin
            m_valid_next = 1'b1;
            m_data_next  = stage_reg;
            m_last_next  = move_last;
            m_done_next  = move_last && end_reg;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NEEDLE_LENGTH: begin
                    needle_length_next = cfg_data[NLEN_REG_W-1:0];
                    count_next         = '0;
                end
                CFG_NEEDLE_TEXT: begin
                    needle_text_next = cfg_data;
                    count_next       = '0;
                end
                CFG_REPLACEMENT_LENGTH: repl_length_next = cfg_data[RLEN_REG_W-1:0];
                CFG_REPLACEMENT_LOW:    repl_low_next    = cfg_data;
                CFG_REPLACEMENT_HIGH:   repl_high_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            needle_length_reg <= '0;
            needle_text_reg   <= '0;
            repl_length_reg   <= '0;
            repl_low_reg      <= '0;
            repl_high_reg     <= '0;
            count_reg         <= '0;
            ri_reg            <= '0;
            stage_valid_reg   <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            needle_length_reg <= needle_length_next;
            needle_text_reg   <= needle_text_next;
            repl_length_reg   <= repl_length_next;
            repl_low_reg      <= repl_low_next;
            repl_high_reg     <= repl_high_next;
            count_reg         <= count_next;
            ri_reg            <= ri_next;
            stage_valid_reg   <= stage_valid_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        byte_reg   <= byte_next;
        end_reg    <= end_next;
        stage_reg  <= stage_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_done_reg <= m_done_next;
    end

endmodule

// ===== tb/sv/tb_stream_find_replace_all.sv =====
// Self-checking testbench for the stream find-and-replace-all block: directed table, then random phases.
module tb_stream_find_replace_all;
    import sfra_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 44;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
        logic              text_done;
    } out_byte_t;

    typedef struct {
        bit                    is_write;
        cfg_index_t            reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [BYTE_W-1:0]     text;
        logic                  present;
        logic                  last_item;
        int                    typed_n;     // -1: rewrite predictor decides
        out_byte_t             typed_out;
    } step_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    wire                    s_tready;
    logic [BYTE_W-1:0]      s_tdata   = '0;  // [7:0] text_byte
    logic                   s_tlast   = 1'b0;  // stream_end
    logic                   s_tuser   = 1'b0;  // [0] byte_present
    wire                    m_tvalid;
    logic                   m_tready  = 1'b0;
    wire  [BYTE_W-1:0]      m_tdata;          // [7:0] result_byte
    wire                    m_tlast;          // run_last
    wire                    m_tuser;          // [0] text_done
    logic                   cfg_valid = 1'b0;
    wire                    cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor copy of the registers and the pending prefix buffer
    logic [NLEN_REG_W-1:0]  needle_len_r = '0;
    logic [CFG_DATA_W-1:0]  needle_txt   = '0;
    logic [RLEN_REG_W-1:0]  repl_len_r   = '0;
    logic [CFG_DATA_W-1:0]  repl_lo      = '0;
    logic [CFG_DATA_W-1:0]  repl_hi      = '0;
    logic [BYTE_W-1:0]      held [NEEDLE_MAX_DEF];
    int                     held_n       = 0;

    out_byte_t fresh_q[$];
    out_byte_t rewritten_q[$];
    step_t     plan[$];

    int sent      = 0;
    int fails     = 0;
    int cycles    = 0;
    int hold_left = 0;
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    stream_find_replace_all DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void emit(logic [BYTE_W-1:0] b);
        fresh_q.push_back({b, 2'b00});
    endfunction

    function automatic void emit_repl();
        int rl;
        rl = (repl_len_r > REPLACEMENT_MAX_DEF) ? REPLACEMENT_MAX_DEF : int'(repl_len_r);
        for (int i = 0; i < rl; i++)
            emit((i < 8) ? repl_lo[8*i +: 8] : repl_hi[8*(i-8) +: 8]);
    endfunction

    function automatic void shift_front();
        emit(held[0]);
        for (int i = 1; i < held_n; i++)
            held[i-1] = held[i];
        held_n--;
    endfunction

    // Rewrite one input transaction into fresh_q and advance the pending buffer.
    function automatic void predict_rewrite(logic [BYTE_W-1:0] b, logic pres, logic fin);
        int nl;
        bit pfx;
        nl = (needle_len_r > NEEDLE_MAX_DEF) ? NEEDLE_MAX_DEF : int'(needle_len_r);
        fresh_q.delete();
        if (nl == 0) begin
            held_n = 0;
            if (pres) begin
                emit_repl();
                emit(b);
            end
            if (fin)
                emit_repl();
        end else begin
            if (pres) begin
                if (held_n < NEEDLE_MAX_DEF) begin
                    held[held_n] = b;
                    held_n++;
                end
                // release front bytes until the rest is again a needle prefix
                while (held_n > 0) begin
                    pfx = (held_n <= nl);
                    for (int i = 0; i < held_n; i++)
                        if (held[i] != needle_txt[8*i +: 8])
                            pfx = 1'b0;
                    if (pfx)
                        break;
                    shift_front();
                end
                if (held_n == nl) begin
                    held_n = 0;
                    emit_repl();
                end
            end
            if (fin)
                while (held_n > 0)
                    shift_front();
        end
        if (fin)
            held_n = 0;
        if (fresh_q.size() > 0) begin
            fresh_q[fresh_q.size()-1].run_last  = 1'b1;
            fresh_q[fresh_q.size()-1].text_done = fin;
        end
    endfunction

    function automatic void plan_cfg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        step_t s;
        s.is_write  = 1'b1;
        s.reg_idx   = idx;
        s.reg_val   = val;
        s.text      = '0;
        s.present   = 1'b0;
        s.last_item = 1'b0;
        s.typed_n   = -1;
        s.typed_out = '0;
        plan.push_back(s);
    endfunction

    function automatic void plan_item(logic [BYTE_W-1:0] b, logic pres, logic fin,
                                      int tn = -1, logic [BYTE_W-1:0] tb = '0, logic td = 1'b0);
        step_t s;
        s.is_write  = 1'b0;
        s.reg_idx   = CFG_NEEDLE_LENGTH;
        s.reg_val   = '0;
        s.text      = b;
        s.present   = pres;
        s.last_item = fin;
        s.typed_n   = tn;
        s.typed_out = {tb, 1'b1, td};
        plan.push_back(s);
    endfunction

    // Drop valid, drain all expected bytes, then give the block time to finish silent steps.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (rewritten_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NEEDLE_LENGTH: begin
                needle_len_r = val[NLEN_REG_W-1:0];
                held_n       = 0;
            end
            CFG_NEEDLE_TEXT: begin
                needle_txt = val;
                held_n     = 0;
            end
            CFG_REPLACEMENT_LENGTH: repl_len_r = val[RLEN_REG_W-1:0];
            CFG_REPLACEMENT_LOW:    repl_lo    = val;
            CFG_REPLACEMENT_HIGH:   repl_hi    = val;
            default: ;
        endcase
    endtask

    task automatic send_text(logic [BYTE_W-1:0] b, logic pres, logic fin,
                             int typed_n = -1, out_byte_t typed_out = '0);
        if (!calm && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= pres;
        s_tlast  <= fin;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_rewrite(b, pres, fin);
        if (typed_n < 0) begin
            foreach (fresh_q[i])
                rewritten_q.push_back(fresh_q[i]);
        end else if (typed_n == 1) begin
            rewritten_q.push_back(typed_out);
        end
        sent++;
    endtask

    task automatic run_phase(int phase);
        logic [BYTE_W-1:0]     alpha [3];
        logic [CFG_DATA_W-1:0] ntext;
        int nl;
        int rl;
        int eff;
        int cut;
        int pick;
        int goal;
        foreach (alpha[i])
            alpha[i] = 8'($urandom);
        case ($urandom_range(9))
            0:       nl = 0;
            1:       nl = NEEDLE_MAX_DEF;
            2:       nl = $urandom_range(15, 9);
            default: nl = $urandom_range(4, 1);
        endcase
        case ($urandom_range(9))
            0:       rl = 0;
            1:       rl = REPLACEMENT_MAX_DEF;
            2:       rl = $urandom_range(31, 17);
            default: rl = $urandom_range(6, 1);
        endcase
        // needle mostly from a two-letter alphabet so prefixes overlap often
        ntext = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            pick = $urandom_range(7);
            ntext[8*i +: 8] = (pick == 0) ? 8'($urandom) : alpha[pick % 2];
        end
        write_reg(CFG_NEEDLE_LENGTH, 64'(nl));
        write_reg(CFG_NEEDLE_TEXT, ntext);
        write_reg(CFG_REPLACEMENT_LENGTH, 64'(rl));
        write_reg(CFG_REPLACEMENT_LOW, {$urandom, $urandom});
        write_reg(CFG_REPLACEMENT_HIGH, {$urandom, $urandom});
        calm = (phase == 4);
        if (phase == 2)
            hold_req = 1'b1;
        eff  = (nl > NEEDLE_MAX_DEF) ? NEEDLE_MAX_DEF : nl;
        goal = sent + PHASE_ITEMS;
        while (sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 45 && eff > 0) begin
                cut = ($urandom_range(3) == 0) ? $urandom_range(eff, 1) : eff;
                for (int i = 0; i < cut; i++)
                    send_text(ntext[8*i +: 8], 1'b1, $urandom_range(29) == 0);
            end else if (pick < 85) begin
                send_text(alpha[$urandom_range(2)], 1'b1, $urandom_range(11) == 0);
            end else if (pick < 93) begin
                send_text(8'($urandom), 1'b1, $urandom_range(11) == 0);
            end else begin
                send_text(8'($urandom), 1'b0, 1'($urandom_range(1)));
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin : result_check
        out_byte_t want;
        if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (rewritten_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("cycle %0d: unexpected result byte %02h last %b done %b",
                             cycles, m_tdata, m_tlast, m_tuser);
            end else begin
                want = rewritten_q.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.run_last ||
                    m_tuser !== want.text_done) begin
                    fails++;
                    if (fails <= 10)
                        $display("cycle %0d: expected byte %02h last %b done %b, got %02h %b %b",
                                 cycles, want.data, want.run_last, want.text_done,
                                 m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    // Receiver side: random idling, and one long hold-off counted here.
    always @(posedge aclk) begin : sink_ready
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    initial begin
        // reset state: empty needle and empty replacement pass bytes straight through
        plan_item(8'h41, 1, 0, 1, 8'h41, 0);
        plan_item(8'h00, 1, 0, 1, 8'h00, 0);
        plan_item(8'h5A, 0, 0, 0);
        plan_item(8'h00, 0, 1, 0);
        plan_item(8'hFF, 1, 1, 1, 8'hFF, 1);
        // needle "ab" -> "XYZ": match, broken prefix, flush at end
        plan_cfg(CFG_NEEDLE_LENGTH, 64'd2);
        plan_cfg(CFG_NEEDLE_TEXT, 64'h6261);
        plan_cfg(CFG_REPLACEMENT_LENGTH, 64'd3);
        plan_cfg(CFG_REPLACEMENT_LOW, 64'h5A5958);
        plan_cfg(CFG_REPLACEMENT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        plan_item(8'h61, 1, 0);
        plan_item(8'h62, 1, 0);
        plan_item(8'h61, 1, 0);
        plan_item(8'h61, 1, 0);
        plan_item(8'h62, 1, 0);
        plan_item(8'h61, 1, 0);
        plan_item(8'h63, 1, 1);
        // rewriting the needle drops the held "a"
        plan_item(8'h61, 1, 0);
        plan_cfg(CFG_NEEDLE_TEXT, 64'h6261);
        plan_item(8'h62, 1, 1);
        // oversized lengths clamp; zero bytes are ordinary
        plan_cfg(CFG_NEEDLE_LENGTH, 64'd15);
        plan_cfg(CFG_NEEDLE_TEXT, 64'h0);
        plan_cfg(CFG_REPLACEMENT_LENGTH, 64'd31);
        plan_cfg(CFG_REPLACEMENT_LOW, 64'h0706_0504_0302_0100);
        plan_cfg(CFG_REPLACEMENT_HIGH, 64'hF0E0_D0C0_B0A0_9080);
        for (int i = 0; i < 8; i++)
            plan_item(8'h00, 1, i == 7);
        // empty needle: replacement around every byte, and alone for an empty stream
        plan_cfg(CFG_NEEDLE_LENGTH, 64'd0);
        plan_cfg(CFG_REPLACEMENT_LENGTH, 64'd16);
        plan_item(8'h71, 1, 1);
        plan_item(8'h00, 0, 1);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (plan[k]) begin
            if (plan[k].is_write)
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            else
                send_text(plan[k].text, plan[k].present, plan[k].last_item,
                          plan[k].typed_n, plan[k].typed_out);
        end
        for (int p = 0; p < PHASES; p++)
            run_phase(p);
        settle();
        fails += rewritten_q.size();
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
